/* hdl/cwt_pkg.sv */
`default_nettype none

package cwt_pkg;

    localparam int unsigned ID_W = 16;

    // Request kinds
    localparam logic [1:0] FUNC_ASSIGN   = 2'd0;
    localparam logic [1:0] FUNC_FINISHED = 2'd1;
    localparam logic [1:0] FUNC_QUERY    = 2'd2;

    // Result status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_FULL      = 2'd1;
    localparam logic [1:0] STS_NOT_FOUND = 2'd2;

    // Match conditions of the table scan
    localparam logic [1:0] SCAN_FREE         = 2'd0;
    localparam logic [1:0] SCAN_CHILD_RUN    = 2'd1;
    localparam logic [1:0] SCAN_PARENT_RUN   = 2'd2;
    localparam logic [1:0] SCAN_PARENT_USED  = 2'd3;

    typedef struct packed {
        logic            accept;
        logic            start;
        logic [1:0]      mode;
        logic            stop;
        logic            asg_wr;
        logic            mark_fin;
        logic            free_ent;
        logic            publish;
        logic [1:0]      res_status;
        logic            res_wake;
        logic            res_has;
    } cwt_cmd_t;

    typedef struct packed {
        logic hit;
        logic last;
        logic out_free;
    } cwt_sts_t;

endpackage

`default_nettype wire

/* hdl/cwt_if.sv */
`default_nettype none

interface cwt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] child_id;
    logic [15:0] parent_id;

    modport source (output valid, output func, output child_id, output parent_id, input ready);
    modport sink (input valid, input func, input child_id, input parent_id, output ready);
endinterface

interface cwt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        wake_parent;
    logic [15:0] woken_parent_id;
    logic        has_children;

    modport source (output valid, output status, output wake_parent,
                    output woken_parent_id, output has_children, input ready);
    modport sink (input valid, input status, input wake_parent,
                  input woken_parent_id, input has_children, output ready);
endinterface

`default_nettype wire

/* hdl/cwt_ram.sv */
`default_nettype none

module cwt_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hdl/cwt_datapath.sv */
`default_nettype none

module cwt_datapath #(
    parameter int unsigned ENTRIES = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cwt_pkg::cwt_cmd_t         cmd,
    output cwt_pkg::cwt_sts_t              sts,
    input  wire logic [cwt_pkg::ID_W-1:0]  req_child,
    input  wire logic [cwt_pkg::ID_W-1:0]  req_parent,
    input  wire logic                      out_ready,
    output logic                           out_valid,
    output logic [1:0]                     out_status,
    output logic                           out_wake,
    output logic [cwt_pkg::ID_W-1:0]       out_woken,
    output logic                           out_has
);

    localparam int unsigned IW = $clog2(ENTRIES);
    localparam int unsigned CW = $clog2(ENTRIES + 1);
    localparam int unsigned DW = 2 * cwt_pkg::ID_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
    localparam logic [CW-1:0] CNT_END  = CW'(ENTRIES);

    // Scan control
    logic              scan_on_reg, scan_on_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              pipe_vld_reg, pipe_vld_next;
    logic [IW-1:0]     pipe_idx_reg, pipe_idx_next;
    logic [1:0]        mode_reg, mode_next;

    // Entry state: used = not free, run = running
    logic [ENTRIES-1:0] used_reg, used_next;
    logic [ENTRIES-1:0] run_reg, run_next;

    // Request payload
    logic [cwt_pkg::ID_W-1:0] child_reg, child_next;
    logic [cwt_pkg::ID_W-1:0] par_reg, par_next;

    // Output register
    logic                     out_vld_reg, out_vld_next;
    logic [1:0]               out_status_reg, out_status_next;
    logic                     out_wake_reg, out_wake_next;
    logic [cwt_pkg::ID_W-1:0] out_woken_reg, out_woken_next;
    logic                     out_has_reg, out_has_next;

    logic                     issue;
    logic [DW-1:0]            rd_data;
    logic [cwt_pkg::ID_W-1:0] rd_parent;
    logic [cwt_pkg::ID_W-1:0] rd_child;
    logic                     e_used;
    logic                     e_run;
    logic                     match;

    cwt_ram #(
        .WIDTH (DW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.asg_wr),
        .waddr (pipe_idx_reg),
        .wdata ({par_reg, child_reg}),
        .raddr (cnt_reg[IW-1:0]),
        .rdata (rd_data)
    );

    assign rd_parent = rd_data[DW-1:cwt_pkg::ID_W];
    assign rd_child  = rd_data[cwt_pkg::ID_W-1:0];
    assign e_used    = used_reg[pipe_idx_reg];
    assign e_run     = run_reg[pipe_idx_reg];
    assign issue     = scan_on_reg && (cnt_reg < CNT_END);

    // Compare the entry read back last cycle
    always_comb
    begin
        case (mode_reg)
            cwt_pkg::SCAN_FREE:        match = !e_used;
            cwt_pkg::SCAN_CHILD_RUN:   match = e_run && (rd_child == child_reg);
            cwt_pkg::SCAN_PARENT_RUN:  match = e_run && (rd_parent == par_reg);
            cwt_pkg::SCAN_PARENT_USED: match = e_used && (rd_parent == par_reg);
            default:                   match = 1'b0;
        endcase
    end

    assign sts.hit      = pipe_vld_reg && match;
    assign sts.last     = pipe_vld_reg && (pipe_idx_reg == LAST_IDX);
    assign sts.out_free = !out_vld_reg || out_ready;

    // Advance the scan pointer and read pipeline
    always_comb
    begin
        scan_on_next  = scan_on_reg;
        cnt_next      = cnt_reg;
        pipe_vld_next = issue;
        pipe_idx_next = cnt_reg[IW-1:0];
        mode_next     = mode_reg;
        if (cmd.start)
        begin
            scan_on_next  = 1'b1;
            cnt_next      = '0;
            pipe_vld_next = 1'b0;
            mode_next     = cmd.mode;
        end
        else if (cmd.stop)
        begin
            scan_on_next  = 1'b0;
            pipe_vld_next = 1'b0;
        end
        else if (issue)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
    end

    // Update entry flags and request payload
    always_comb
    begin
        used_next  = used_reg;
        run_next   = run_reg;
        child_next = child_reg;
        par_next   = par_reg;
        if (cmd.asg_wr)
        begin
            used_next[pipe_idx_reg] = 1'b1;
            run_next[pipe_idx_reg]  = 1'b1;
        end
        if (cmd.mark_fin)
        begin
            run_next[pipe_idx_reg] = 1'b0;
            par_next               = rd_parent;
        end
        if (cmd.free_ent)
        begin
            used_next[pipe_idx_reg] = 1'b0;
            run_next[pipe_idx_reg]  = 1'b0;
        end
        if (cmd.accept)
        begin
            child_next = req_child;
            par_next   = req_parent;
        end
    end

    // Load or drain the output register
    always_comb
    begin
        out_vld_next    = out_vld_reg && !out_ready;
        out_status_next = out_status_reg;
        out_wake_next   = out_wake_reg;
        out_woken_next  = out_woken_reg;
        out_has_next    = out_has_reg;
        if (cmd.publish)
        begin
            out_vld_next    = 1'b1;
            out_status_next = cmd.res_status;
            out_wake_next   = cmd.res_wake;
            out_woken_next  = cmd.res_wake ? par_reg : '0;
            out_has_next    = cmd.res_has;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_on_reg  <= 1'b0;
            cnt_reg      <= '0;
            pipe_vld_reg <= 1'b0;
            mode_reg     <= cwt_pkg::SCAN_FREE;
            used_reg     <= '0;
            run_reg      <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            scan_on_reg  <= scan_on_next;
            cnt_reg      <= cnt_next;
            pipe_vld_reg <= pipe_vld_next;
            mode_reg     <= mode_next;
            used_reg     <= used_next;
            run_reg      <= run_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_idx_reg   <= pipe_idx_next;
        child_reg      <= child_next;
        par_reg        <= par_next;
        out_status_reg <= out_status_next;
        out_wake_reg   <= out_wake_next;
        out_woken_reg  <= out_woken_next;
        out_has_reg    <= out_has_next;
    end

    assign out_valid  = out_vld_reg;
    assign out_status = out_status_reg;
    assign out_wake   = out_wake_reg;
    assign out_woken  = out_woken_reg;
    assign out_has    = out_has_reg;

endmodule

`default_nettype wire

/* hdl/cwt_ctrl.sv */
`default_nettype none

module cwt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [1:0]        in_func,
    output logic                   in_ready,
    input  wire cwt_pkg::cwt_sts_t sts,
    output cwt_pkg::cwt_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ASG  = 3'd1;
    localparam logic [2:0] S_FIND = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_FREE = 3'd4;
    localparam logic [2:0] S_QRY  = 3'd5;
    localparam logic [2:0] S_RES  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] rstat_reg, rstat_next;
    logic       rwake_reg, rwake_next;
    logic       rhas_reg, rhas_next;

    assign in_ready = (state_reg == S_IDLE);

    // Sequence the scans of each request
    always_comb
    begin
        state_next = state_reg;
        rstat_next = rstat_reg;
        rwake_next = rwake_reg;
        rhas_next  = rhas_reg;
        cmd        = '0;
        cmd.res_status = rstat_reg;
        cmd.res_wake   = rwake_reg;
        cmd.res_has    = rhas_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    cmd.start  = 1'b1;
                    rstat_next = cwt_pkg::STS_OK;
                    rwake_next = 1'b0;
                    rhas_next  = 1'b0;
                    case (in_func)
                        cwt_pkg::FUNC_ASSIGN:
                        begin
                            cmd.mode   = cwt_pkg::SCAN_FREE;
                            state_next = S_ASG;
                        end
                        cwt_pkg::FUNC_FINISHED:
                        begin
                            cmd.mode   = cwt_pkg::SCAN_CHILD_RUN;
                            state_next = S_FIND;
                        end
                        cwt_pkg::FUNC_QUERY:
                        begin
                            cmd.mode   = cwt_pkg::SCAN_PARENT_USED;
                            state_next = S_QRY;
                        end
                        default:
                        begin
                            cmd.start  = 1'b0;
                            state_next = S_RES;
                        end
                    endcase
                end
            end
            S_ASG:
            begin
                if (sts.hit)
                begin
                    cmd.asg_wr = 1'b1;
                    cmd.stop   = 1'b1;
                    state_next = S_RES;
                end
                else if (sts.last)
                begin
                    cmd.stop   = 1'b1;
                    rstat_next = cwt_pkg::STS_FULL;
                    state_next = S_RES;
                end
            end
            S_FIND:
            begin
                if (sts.hit)
                begin
                    cmd.mark_fin = 1'b1;
                    cmd.start    = 1'b1;
                    cmd.mode     = cwt_pkg::SCAN_PARENT_RUN;
                    state_next   = S_CHK;
                end
                else if (sts.last)
                begin
                    cmd.stop   = 1'b1;
                    rstat_next = cwt_pkg::STS_NOT_FOUND;
                    state_next = S_RES;
                end
            end
            S_CHK:
            begin
                if (sts.hit)
                begin
                    cmd.stop   = 1'b1;
                    state_next = S_RES;
                end
                else if (sts.last)
                begin
                    cmd.start  = 1'b1;
                    cmd.mode   = cwt_pkg::SCAN_PARENT_USED;
                    state_next = S_FREE;
                end
            end
            S_FREE:
            begin
                cmd.free_ent = sts.hit;
                if (sts.last)
                begin
                    cmd.stop   = 1'b1;
                    rwake_next = 1'b1;
                    state_next = S_RES;
                end
            end
            S_QRY:
            begin
                if (sts.hit)
                begin
                    cmd.stop   = 1'b1;
                    rhas_next  = 1'b1;
                    state_next = S_RES;
                end
                else if (sts.last)
                begin
                    cmd.stop   = 1'b1;
                    state_next = S_RES;
                end
            end
            S_RES:
            begin
                if (sts.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rstat_reg <= cwt_pkg::STS_OK;
            rwake_reg <= 1'b0;
            rhas_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rstat_reg <= rstat_next;
            rwake_reg <= rwake_next;
            rhas_reg  <= rhas_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/child_wait_tracking_table_core.sv */
// One request at a time; each walks the table one entry per cycle through the
// table RAM's registered read port. Assign and query use a single scan. Child
// finished runs a child scan, a running-sibling scan and a freeing scan in turn,
// stopping early if the child is not found or a sibling runs; the ignored kind
// does no scan. Next request is taken the cycle after the result is staged in the
// output register. Reset clears every entry to free at once via per-entry flops.
`default_nettype none

module child_wait_tracking_table_core #(
    parameter int unsigned TABLE_ENTRIES = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cwt_in_if.sink     req,
    cwt_out_if.source  rsp
);

    cwt_pkg::cwt_cmd_t cmd;
    cwt_pkg::cwt_sts_t sts;
    logic              in_ready;

    assign req.ready = in_ready;

    cwt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_func  (req.func),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cwt_datapath #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .req_child  (req.child_id),
        .req_parent (req.parent_id),
        .out_ready  (rsp.ready),
        .out_valid  (rsp.valid),
        .out_status (rsp.status),
        .out_wake   (rsp.wake_parent),
        .out_woken  (rsp.woken_parent_id),
        .out_has    (rsp.has_children)
    );

endmodule

`default_nettype wire

/* hdl/cwt_checker.sv */
`default_nettype none

module cwt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [1:0]  rsp_status,
    input wire logic        rsp_wake,
    input wire logic [15:0] rsp_woken,
    input wire logic        rsp_has
);

    // A held result keeps its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_wake) && $stable(rsp_woken) && $stable(rsp_has))
        else $error("result changed while stalled");

    // One request in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // Wake only comes with a clean finish
    a_wake_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_wake |-> rsp_status == cwt_pkg::STS_OK && !rsp_has)
        else $error("wake with bad status");

    // Woken id is zero unless waking
    a_woken_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_wake |-> rsp_woken == 16'd0)
        else $error("woken id without wake");

    // Query answer never carries an error
    a_has_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_has |-> rsp_status == cwt_pkg::STS_OK)
        else $error("query answer with error status");

endmodule

bind child_wait_tracking_table_core cwt_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_wake   (rsp.wake_parent),
    .rsp_woken  (rsp.woken_parent_id),
    .rsp_has    (rsp.has_children)
);

`default_nettype wire
